### hw/rtl/sear_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the address range matcher.
// No dependencies; every other file imports this package.
package sear_pkg;

    localparam int C_NUM_COMMANDS  = 64;
    localparam int C_LINE_BITS     = 32;
    localparam int ID_BITS         = 6;
    localparam int LINE_FIELD_BITS = 32;
    localparam int KIND_BITS       = 3;
    localparam int Q_DEPTH         = 2;

    localparam logic [KIND_BITS-1:0] K_NONE  = 3'd0;
    localparam logic [KIND_BITS-1:0] K_LAST  = 3'd1;
    localparam logic [KIND_BITS-1:0] K_LINE  = 3'd2;
    localparam logic [KIND_BITS-1:0] K_LINE0 = 3'd3;
    localparam logic [KIND_BITS-1:0] K_STEP  = 3'd4;
    localparam logic [KIND_BITS-1:0] K_REGEX = 3'd5;

    localparam logic ACT_EVAL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic [1:0] NADDR_ZERO = 2'd0;
    localparam logic [1:0] NADDR_ONE  = 2'd1;

    typedef struct packed {
        logic                       action;
        logic [ID_BITS-1:0]         cmd_id;
        logic [1:0]                 addr_count;
        logic                       negate;
        logic [KIND_BITS-1:0]       kind_first;
        logic [LINE_FIELD_BITS-1:0] value_first;
        logic [LINE_FIELD_BITS-1:0] step_first;
        logic [KIND_BITS-1:0]       kind_second;
        logic [LINE_FIELD_BITS-1:0] value_second;
        logic [LINE_FIELD_BITS-1:0] line_number;
        logic                       is_last_line;
        logic [1:0]                 regex_hits;
    } t_in;

    typedef struct packed {
        logic active;
        logic range_closed;
    } t_out;

    typedef enum logic [1:0] {
        MODE_ALL,
        MODE_FIRST,
        MODE_RANGE
    } t_mode;

    typedef struct packed {
        logic                       clear;
        t_mode                      mode;
        logic [ID_BITS-1:0]         idx;
        logic                       negate;
        logic                       hit;
        logic                       need_mod;
        logic [LINE_FIELD_BITS-1:0] diff;
        logic [LINE_FIELD_BITS-1:0] step;
        logic                       close_now;
        logic                       shut_fixed;
        logic                       shut_regex;
        logic [LINE_FIELD_BITS-1:0] line;
    } t_op;

endpackage

### hw/rtl/sear_in_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one address request.
// Depends on sear_pkg for the payload type.
interface sear_in_if
    import sear_pkg::*;
();
    logic valid;
    logic ready;
    t_in  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sear_out_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one match result.
// Depends on sear_pkg for the payload type.
interface sear_out_if
    import sear_pkg::*;
();
    logic valid;
    logic ready;
    t_out data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sear_front.sv
`timescale 1ns / 1ps
// Front end: classifies an incoming request into a decoded operation.
// Depends on sear_pkg.
module sear_front
    import sear_pkg::*;
#(
    parameter int NUM_COMMANDS = C_NUM_COMMANDS,
    parameter int LINE_BITS    = C_LINE_BITS
) (
    input  t_in i_in,
    output t_op o_op
);
    localparam int LW = (LINE_BITS < LINE_FIELD_BITS) ? LINE_BITS : LINE_FIELD_BITS;

    logic [LINE_FIELD_BITS-1:0] line;
    logic [LINE_FIELD_BITS-1:0] v1;
    logic [LINE_FIELD_BITS-1:0] s1;
    logic [LINE_FIELD_BITS-1:0] v2;
    logic [LINE_FIELD_BITS-1:0] diff;
    logic                       in_range;
    logic                       hit;
    logic                       shut_fixed;

    assign line     = LINE_FIELD_BITS'(i_in.line_number[LW-1:0]);
    assign v1       = LINE_FIELD_BITS'(i_in.value_first[LW-1:0]);
    assign s1       = LINE_FIELD_BITS'(i_in.step_first[LW-1:0]);
    assign v2       = LINE_FIELD_BITS'(i_in.value_second[LW-1:0]);
    assign diff     = line - v1;
    assign in_range = (32'(i_in.cmd_id) < 32'(NUM_COMMANDS));

    always_comb begin
        unique case (i_in.kind_first)
            K_LAST:  hit = i_in.is_last_line;
            K_LINE:  hit = (line == v1);
            K_LINE0: hit = (line <= LINE_FIELD_BITS'(1));
            K_STEP:  hit = (s1 == '0) && (line == v1);
            K_REGEX: hit = i_in.regex_hits[0];
            default: hit = 1'b0;
        endcase
    end

    always_comb begin
        unique case (i_in.kind_second)
            K_LINE:  shut_fixed = (line >= v2);
            K_LAST:  shut_fixed = i_in.is_last_line;
            K_LINE0: shut_fixed = 1'b1;
            default: shut_fixed = 1'b0;
        endcase
    end

    always_comb begin
        o_op.clear = (i_in.action == ACT_CLEAR);
        if (i_in.addr_count == NADDR_ZERO) begin
            o_op.mode = MODE_ALL;
        end else if (i_in.addr_count == NADDR_ONE || !in_range) begin
            o_op.mode = MODE_FIRST;
        end else begin
            o_op.mode = MODE_RANGE;
        end
        o_op.idx        = in_range ? i_in.cmd_id : '0;
        o_op.negate     = i_in.negate;
        o_op.hit        = hit;
        o_op.need_mod   = (i_in.kind_first == K_STEP) && (s1 != '0) && (line >= v1);
        o_op.diff       = LINE_FIELD_BITS'(diff[LW-1:0]);
        o_op.step       = s1;
        o_op.close_now  = (i_in.kind_second == K_LINE) && (v2 <= line);
        o_op.shut_fixed = shut_fixed;
        o_op.shut_regex = (i_in.kind_second == K_REGEX) && i_in.regex_hits[1];
        o_op.line       = line;
    end
endmodule

### hw/rtl/sear_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of decoded operations between the front and back ends.
// Depends on sear_pkg.
module sear_queue
    import sear_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_op  o_op
);
    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_op           r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end
endmodule

### hw/rtl/sear_rem.sv
`timescale 1ns / 1ps
// Restoring remainder unit, one dividend bit per cycle; reports a zero remainder.
// Depends on sear_pkg.
module sear_rem
    import sear_pkg::*;
#(
    parameter int LINE_BITS = C_LINE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [LINE_FIELD_BITS-1:0] i_dividend,
    input  logic [LINE_FIELD_BITS-1:0] i_divisor,
    output logic                       o_busy,
    output logic                       o_zero
);
    localparam int LW = (LINE_BITS < LINE_FIELD_BITS) ? LINE_BITS : LINE_FIELD_BITS;
    localparam int CW = $clog2(LW + 1);

    logic [CW-1:0] r_cnt;
    logic [LW-1:0] r_dvd;
    logic [LW-1:0] r_dvs;
    logic [LW-1:0] r_rem;
    logic [LW:0]   rem_sh;
    logic [LW:0]   rem_sub;

    assign rem_sh  = {r_rem, r_dvd[LW-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign o_busy  = (r_cnt != '0);
    assign o_zero  = (r_rem == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(LW);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend[LW-1:0];
            r_dvs <= i_divisor[LW-1:0];
            r_rem <= '0;
        end else if (o_busy) begin
            r_dvd <= {r_dvd[LW-2:0], 1'b0};
            r_rem <= (rem_sh >= {1'b0, r_dvs}) ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
        end
    end
endmodule

### hw/rtl/sear_back.sv
`timescale 1ns / 1ps
// Back end: executes decoded operations against the range table and drives results.
// Depends on sear_pkg and sear_out_if.
module sear_back
    import sear_pkg::*;
#(
    parameter int NUM_COMMANDS = C_NUM_COMMANDS,
    parameter int LINE_BITS    = C_LINE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_op         i_q_op,
    output logic        o_pop,
    output logic        o_rem_start,
    input  logic        i_rem_busy,
    input  logic        i_rem_zero,
    sear_out_if.source  o_res
);
    localparam int LW    = (LINE_BITS < LINE_FIELD_BITS) ? LINE_BITS : LINE_FIELD_BITS;
    localparam int DEPTH = (NUM_COMMANDS < (1 << ID_BITS)) ? NUM_COMMANDS : (1 << ID_BITS);
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EXEC
    } t_state;

    t_state           r_state;
    t_op              r_op;
    logic [DEPTH-1:0] r_open;
    logic             r_out_valid;
    t_out             r_out;
    logic [LW-1:0]    r_mem [DEPTH];
    logic [LW-1:0]    r_rd_data;

    logic [IW-1:0]    idx;
    logic             hit;
    logic             cur_open;
    logic             commit;
    logic             result;
    logic             closed;
    logic             open_next;
    logic             wr_en;

    assign o_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_rem_start = o_pop && i_q_op.need_mod;
    assign idx         = r_op.idx[IW-1:0];
    assign hit         = r_op.need_mod ? i_rem_zero : r_op.hit;
    assign cur_open    = r_open[idx];
    assign commit      = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        result    = 1'b1;
        closed    = 1'b1;
        open_next = cur_open;
        wr_en     = 1'b0;
        unique case (r_op.mode)
            MODE_ALL: begin
                result = 1'b1;
            end
            MODE_FIRST: begin
                result = hit;
            end
            MODE_RANGE: begin
                if (!cur_open) begin
                    result = hit;
                    if (hit) begin
                        wr_en     = 1'b1;
                        open_next = !r_op.close_now;
                        closed    = r_op.close_now;
                    end
                end else begin
                    open_next = !(r_op.shut_fixed ||
                                  (r_op.shut_regex && (r_op.line[LW-1:0] > r_rd_data)));
                    closed    = !open_next;
                end
            end
            default: begin
                result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_open      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_op    <= i_q_op;
                        r_state <= i_q_op.need_mod ? S_DIV : S_EXEC;
                    end
                end
                S_DIV: begin
                    if (!i_rem_busy) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state <= S_IDLE;
                        if (r_op.clear) begin
                            r_open             <= '0;
                            r_out.active       <= 1'b0;
                            r_out.range_closed <= 1'b1;
                        end else begin
                            r_open[idx]        <= open_next;
                            r_out.active       <= result ^ r_op.negate;
                            r_out.range_closed <= closed;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_data <= r_mem[i_q_op.idx[IW-1:0]];
        end
        if (commit && !r_op.clear && wr_en) begin
            r_mem[idx] <= r_op.line[LW-1:0];
        end
    end
endmodule

### hw/rtl/stream_editor_address_range_matcher.sv
`timescale 1ns / 1ps
// Address range matcher: one result per request, in order.
// Each request is queued, popped by the back end when it is idle, and executed into a registered result;
// a first~step address that needs its remainder first waits for the bit-serial remainder unit.
// The back end finishes one request before it pops the next; meanwhile the queue holds up to two more.
// Synchronous reset closes every range; start lines stay undefined until written.
module stream_editor_address_range_matcher
    import sear_pkg::*;
#(
    parameter int NUM_COMMANDS = C_NUM_COMMANDS,
    parameter int LINE_BITS    = C_LINE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sear_in_if.sink    i_req,
    sear_out_if.source o_res
);
    t_op  front_op;
    t_op  q_op;
    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic rem_start;
    logic rem_busy;
    logic rem_zero;

    assign i_req.ready = !q_full;
    assign push        = i_req.valid && !q_full;

    sear_front #(
        .NUM_COMMANDS (NUM_COMMANDS),
        .LINE_BITS    (LINE_BITS)
    ) u_front (
        .i_in (i_req.data),
        .o_op (front_op)
    );

    sear_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    sear_rem #(
        .LINE_BITS (LINE_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (q_op.diff),
        .i_divisor  (q_op.step),
        .o_busy     (rem_busy),
        .o_zero     (rem_zero)
    );

    sear_back #(
        .NUM_COMMANDS (NUM_COMMANDS),
        .LINE_BITS    (LINE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_op),
        .o_pop       (q_pop),
        .o_rem_start (rem_start),
        .i_rem_busy  (rem_busy),
        .i_rem_zero  (rem_zero),
        .o_res       (o_res)
    );
endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stream_editor_address_range_matcher, with directed and random requests.
// Depends on sear_pkg, sear_in_if, sear_out_if and the matcher RTL.
module tb;
    import sear_pkg::*;

    localparam logic [1:0]           NADDR_TWO    = 2'd2;
    localparam logic [1:0]           NADDR_THREE  = 2'd3;
    localparam logic [KIND_BITS-1:0] KIND_BAD6    = 3'd6;
    localparam logic [KIND_BITS-1:0] KIND_BAD7    = 3'd7;
    localparam int                   IDLE_PERCENT = 31;
    localparam int                   STALL_LIMIT  = 5000;
    localparam int                   FILE_ITEMS   = 1300;
    localparam int                   TOTAL_ITEMS  = 1600;
    localparam logic [31:0]          ALL_ONES     = 32'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;

    sear_in_if  req_if ();
    sear_out_if res_if ();

    stream_editor_address_range_matcher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    logic                       range_is_open [C_NUM_COMMANDS];
    logic [C_LINE_BITS-1:0]     range_first_line [C_NUM_COMMANDS];
    t_out                       pending_matches [$];
    int                         mismatches = 0;
    int                         sent_count = 0;
    int                         stall_cycles = 0;
    logic                       steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_in make_req(
        input logic act, input logic [5:0] id, input logic [1:0] naddr, input logic neg,
        input logic [2:0] k1, input logic [31:0] v1, input logic [31:0] s1,
        input logic [2:0] k2, input logic [31:0] v2, input logic [31:0] line_no,
        input logic last_flag, input logic [1:0] hits);
        t_in r;
        r.action       = act;
        r.cmd_id       = id;
        r.addr_count   = naddr;
        r.negate       = neg;
        r.kind_first   = k1;
        r.value_first  = v1;
        r.step_first   = s1;
        r.kind_second  = k2;
        r.value_second = v2;
        r.line_number  = line_no;
        r.is_last_line = last_flag;
        r.regex_hits   = hits;
        return r;
    endfunction

    function automatic logic first_address_hit(input t_in r);
        logic [31:0] offset;
        offset = r.line_number - r.value_first;
        case (r.kind_first)
            K_LAST:  return r.is_last_line;
            K_LINE:  return r.line_number == r.value_first;
            K_LINE0: return r.line_number <= 32'd1;
            K_STEP: begin
                if (r.step_first == '0) return r.line_number == r.value_first;
                return (r.line_number >= r.value_first) && ((offset % r.step_first) == '0);
            end
            K_REGEX: return r.regex_hits[0];
            default: return 1'b0;
        endcase
    endfunction

    function automatic t_out predict_match(input t_in r);
        t_out        res;
        logic        hit;
        logic        shut;
        int unsigned id;
        res.active       = 1'b0;
        res.range_closed = 1'b1;
        id  = r.cmd_id;
        hit = first_address_hit(r);
        if (r.action == ACT_CLEAR) begin
            for (int i = 0; i < C_NUM_COMMANDS; i++) range_is_open[i] = 1'b0;
            return res;
        end
        if (r.addr_count == NADDR_ZERO) begin
            res.active = 1'b1;
        end else if (r.addr_count == NADDR_ONE || id >= C_NUM_COMMANDS) begin
            res.active = hit;
        end else if (!range_is_open[id]) begin
            if (hit) begin
                range_first_line[id] = r.line_number;
                range_is_open[id] = !(r.kind_second == K_LINE &&
                                      r.value_second <= r.line_number);
                res.active = 1'b1;
            end
            res.range_closed = !range_is_open[id];
        end else begin
            shut = 1'b0;
            case (r.kind_second)
                K_LINE:  shut = r.line_number >= r.value_second;
                K_LAST:  shut = r.is_last_line;
                K_LINE0: shut = 1'b1;
                K_REGEX: shut = (r.line_number > range_first_line[id]) && r.regex_hits[1];
                default: shut = 1'b0;
            endcase
            if (shut) range_is_open[id] = 1'b0;
            res.active = 1'b1;
            res.range_closed = !range_is_open[id];
        end
        if (r.negate) res.active = !res.active;
        return res;
    endfunction

    task automatic send_request(input t_in r);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do @(posedge i_clk); while (!req_if.ready);
        pending_matches.insert(pending_matches.size(), predict_match(r));
        sent_count++;
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in random_command(input logic [31:0] base);
        t_in r;
        int  pick;
        r = '0;
        r.action = ACT_EVAL;
        r.cmd_id = 6'($urandom_range(0, C_NUM_COMMANDS - 1));
        pick = $urandom_range(0, 9);
        r.addr_count = (pick < 6) ? NADDR_TWO : (pick == 6) ? NADDR_THREE :
                       (pick < 9) ? NADDR_ONE : NADDR_ZERO;
        r.negate = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 11);
        r.kind_first = (pick < 10) ? 3'($urandom_range(K_LAST, K_REGEX)) :
                       3'($urandom_range(0, 7));
        r.value_first = base + $urandom_range(0, 10);
        r.step_first  = $urandom_range(0, 4);
        pick = $urandom_range(0, 11);
        r.kind_second = (pick < 9) ? 3'($urandom_range(K_LAST, K_REGEX)) :
                        3'($urandom_range(0, 7));
        r.value_second = base + $urandom_range(0, 25);
        return r;
    endfunction

    task automatic test_address_kinds();
        send_request(make_req(ACT_EVAL, 0, NADDR_ZERO, 0, K_NONE, 0, 0, K_NONE, 0, 0, 0, 0));
        send_request(make_req(ACT_EVAL, 1, NADDR_ZERO, 1, K_LINE, ALL_ONES, ALL_ONES,
                              K_LINE, ALL_ONES, ALL_ONES, 1, 3));
        send_request(make_req(ACT_EVAL, 2, NADDR_ONE, 0, K_NONE, 0, 0, K_NONE, 0, 5, 0, 3));
        send_request(make_req(ACT_EVAL, 3, NADDR_ONE, 0, K_LAST, 0, 0, K_NONE, 0, 9, 1, 0));
        send_request(make_req(ACT_EVAL, 4, NADDR_ONE, 0, K_LINE, ALL_ONES, 0,
                              K_NONE, 0, ALL_ONES, 0, 0));
        send_request(make_req(ACT_EVAL, 5, NADDR_ONE, 0, K_LINE0, 0, 0, K_NONE, 0, 0, 0, 0));
        send_request(make_req(ACT_EVAL, 6, NADDR_ONE, 1, K_LINE0, 0, 0, K_NONE, 0, 2, 0, 0));
        send_request(make_req(ACT_EVAL, 7, NADDR_ONE, 0, K_STEP, 3, 0, K_NONE, 0, 3, 0, 0));
        send_request(make_req(ACT_EVAL, 8, NADDR_ONE, 0, K_STEP, 1, ALL_ONES,
                              K_NONE, 0, 0, 0, 0));
        send_request(make_req(ACT_EVAL, 9, NADDR_ONE, 0, K_STEP, 32'h8000_0000, 7,
                              K_NONE, 0, 32'h8000_0023, 0, 0));
        send_request(make_req(ACT_EVAL, 10, NADDR_ONE, 0, K_REGEX, 0, 0, K_NONE, 0, 12, 0, 1));
        send_request(make_req(ACT_EVAL, 11, NADDR_ONE, 0, KIND_BAD7, 1, 0,
                              K_NONE, 0, 1, 1, 3));
        send_request(make_req(ACT_EVAL, 12, NADDR_ONE, 0, KIND_BAD6, 1, 0,
                              K_NONE, 0, 1, 1, 3));
    endtask

    task automatic test_range_closure();
        send_request(make_req(ACT_EVAL, 20, NADDR_TWO, 0, K_LINE, 10, 0, K_LINE, 10, 10, 0, 0));
        send_request(make_req(ACT_EVAL, 21, NADDR_THREE, 0, K_REGEX, 0, 0,
                              K_REGEX, 0, 4, 0, 3));
        send_request(make_req(ACT_EVAL, 21, NADDR_THREE, 0, K_REGEX, 0, 0,
                              K_REGEX, 0, 5, 0, 2));
        send_request(make_req(ACT_EVAL, 22, NADDR_TWO, 0, K_LINE0, 0, 0, K_STEP, 0, 1, 0, 0));
        send_request(make_req(ACT_EVAL, 22, NADDR_TWO, 1, K_LINE0, 0, 0, K_STEP, 0, 2, 1, 3));
        send_request(make_req(ACT_EVAL, 23, NADDR_TWO, 0, K_LINE, 2, 0, KIND_BAD6, 0, 2, 0, 0));
        send_request(make_req(ACT_CLEAR, 23, NADDR_TWO, 1, K_LINE0, ALL_ONES, ALL_ONES,
                              K_LINE0, ALL_ONES, ALL_ONES, 1, 3));
        send_request(make_req(ACT_EVAL, 22, NADDR_TWO, 0, K_LINE0, 0, 0, K_STEP, 0, 3, 0, 0));
        send_request(make_req(ACT_EVAL, 24, NADDR_TWO, 0, K_STEP, 2, 3, K_LAST, 0, 2, 0, 0));
        send_request(make_req(ACT_EVAL, 24, NADDR_TWO, 0, K_STEP, 2, 3, K_LAST, 0, 9, 1, 0));
        send_request(make_req(ACT_EVAL, 63, NADDR_TWO, 0, K_LINE, 1, 0, K_LINE0, 0, 1, 0, 0));
        send_request(make_req(ACT_EVAL, 63, NADDR_TWO, 0, K_LINE, 1, 0, K_LINE0, 0, 2, 0, 0));
        send_request(make_req(ACT_EVAL, 25, NADDR_TWO, 0, K_LINE, 5, 0,
                              K_LINE, ALL_ONES, 5, 0, 0));
        send_request(make_req(ACT_EVAL, 25, NADDR_TWO, 0, K_LINE, 5, 0,
                              K_NONE, ALL_ONES, 6, 0, 0));
    endtask

    // Each pass models one input file: a few commands evaluated on every line in turn,
    // usually followed by the clear that marks the file boundary.
    task automatic test_random_files(input int target);
        t_in         cmds [4];
        t_in         r;
        int          n_cmds;
        int          n_lines;
        logic [31:0] base;
        while (sent_count < target) begin
            steady  = (sent_count >= 400 && sent_count < 650);
            n_cmds  = $urandom_range(1, 4);
            n_lines = $urandom_range(3, 30);
            base    = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2);
            for (int c = 0; c < n_cmds; c++) cmds[c] = random_command(base);
            for (int ln = 0; ln < n_lines; ln++) begin
                for (int c = 0; c < n_cmds; c++) begin
                    r = cmds[c];
                    r.line_number  = base + ln;
                    r.is_last_line = (ln == n_lines - 1);
                    r.regex_hits   = {($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0)};
                    send_request(r);
                end
            end
            if ($urandom_range(0, 2) != 0) begin
                r = random_command($urandom);
                r.action = ACT_CLEAR;
                send_request(r);
            end
            if ($urandom_range(0, 9) == 0) wait_for_results();
        end
        steady = 1'b0;
    endtask

    task automatic test_random_noise(input int target);
        t_in r;
        int  pick;
        while (sent_count < target) begin
            r.action       = ($urandom_range(0, 15) == 0) ? ACT_CLEAR : ACT_EVAL;
            r.cmd_id       = 6'($urandom_range(0, C_NUM_COMMANDS - 1));
            r.addr_count   = 2'($urandom_range(0, 3));
            r.negate       = 1'($urandom_range(0, 1));
            r.kind_first   = 3'($urandom_range(0, 7));
            r.value_first  = $urandom;
            pick           = $urandom_range(0, 2);
            r.step_first   = (pick == 0) ? $urandom : (pick == 1) ? $urandom_range(0, 3) : '0;
            r.kind_second  = 3'($urandom_range(0, 7));
            r.value_second = $urandom;
            r.line_number  = $urandom_range(0, 1) ? $urandom :
                             r.value_first + $urandom_range(0, 8);
            r.is_last_line = 1'($urandom_range(0, 1));
            r.regex_hits   = 2'($urandom_range(0, 3));
            send_request(r);
        end
    endtask

    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: active=%0b range_closed=%0b",
                             res_if.data.active, res_if.data.range_closed);
            end else begin
                want = pending_matches.pop_front();
                if (want.active !== res_if.data.active ||
                    want.range_closed !== res_if.data.range_closed) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected active=%0b range_closed=%0b, %s%0b %s%0b",
                                 want.active, want.range_closed,
                                 "got active=", res_if.data.active,
                                 "range_closed=", res_if.data.range_closed);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("FAIL stream_editor_address_range_matcher");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        for (int i = 0; i < C_NUM_COMMANDS; i++) begin
            range_is_open[i]    = 1'b0;
            range_first_line[i] = '0;
        end
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_address_kinds();
        wait_for_results();
        test_range_closure();
        wait_for_results();
        test_random_files(FILE_ITEMS);
        wait_for_results();
        test_random_noise(TOTAL_ITEMS);
        wait_for_results();
        repeat (C_LINE_BITS + 8) @(posedge i_clk);

        if (mismatches == 0 && pending_matches.size() == 0) begin
            $display("PASS stream_editor_address_range_matcher");
        end else begin
            $display("FAIL stream_editor_address_range_matcher");
        end
        $finish;
    end

endmodule
